// File: sv/qea_pkg.sv
package qea_pkg;

    // Working width of one quaternion component after input scaling.
    localparam int CW = 16;
    // Widths of the arctangent operands along the datapath.
    localparam int ARG_W = 35;
    localparam int PRE_W = 42;
    localparam int COR_W = 46;
    localparam int ANG_W = 34;
    localparam int PRE_LIMIT_LOG = 40;

    localparam int SQRT_STEPS   = 32;
    localparam int CORDIC_STEPS = 30;

    // Lanes of the arctangent datapath.
    localparam int LANE_ROLL  = 0;
    localparam int LANE_PITCH = 1;
    localparam int LANE_YAW   = 2;
    localparam int LANES      = 3;

    localparam logic [31:0]        PI_Q30        = 32'd3373259426;
    localparam logic signed [15:0] HALF_PI_Q13   = 16'sd12868;
    localparam logic signed [15:0] PI_Q13        = 16'sd25736;
    localparam logic signed [16:0] TWO_PI_Q13    = 17'sd51472;
    localparam logic signed [16:0] ROLL_WRAP_Q13 = -17'sd20480;
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sd1073741824;

    // Arctangent of 2^-i in binary angle units, full turn = 2^32.
    localparam logic [ANG_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
        34'h20000000, 34'h12E4051E, 34'h09FB385B, 34'h051111D4, 34'h028B0D43,
        34'h0145D7E1, 34'h00A2F61E, 34'h00517C55, 34'h0028BE53, 34'h00145F2F,
        34'h000A2F98, 34'h000517CC, 34'h00028BE6, 34'h000145F3, 34'h0000A2F9,
        34'h0000517C, 34'h000028BE, 34'h0000145F, 34'h00000A2F, 34'h00000517,
        34'h0000028B, 34'h00000145, 34'h000000A2, 34'h00000051, 34'h00000028,
        34'h00000014, 34'h0000000A, 34'h00000005, 34'h00000002, 34'h00000001
    };

    typedef struct packed {
        logic signed [ARG_W-1:0] x;
        logic signed [ARG_W-1:0] y;
    } t_arg;

    typedef struct packed {
        logic signed [PRE_W-1:0] x;
        logic signed [PRE_W-1:0] y;
    } t_pre;

    typedef struct packed {
        logic signed [COR_W-1:0] x;
        logic signed [COR_W-1:0] y;
        logic signed [ANG_W-1:0] ang;
        logic                    zero;
    } t_cord;

    typedef struct packed {
        logic nz;
        logic satp;
        logic satn;
    } t_flags;

    typedef struct packed {
        t_arg                    roll;
        t_arg                    yaw;
        logic signed [ARG_W-1:0] h;
        t_flags                  f;
    } t_side;

endpackage

// File: sv/quaternion_to_euler_angles_core.sv
// Quaternion to roll, pitch and yaw. One quaternion word enters per clock and one angle
// word leaves per clock unless the output stalls. The pipeline holds the 32-stage square
// root that forms the pitch cosine term and the 30-stage CORDIC vectoring array that serves
// roll, pitch and yaw side by side. Angles are Q3.13 radians; roll below -2.5 rad is
// wrapped by a full turn, pitch is clamped to plus or minus pi/2 with a flag, and a zero
// quaternion gives all zeros. A stall at the output holds the whole pipeline in place.
module quaternion_to_euler_angles_core
    import qea_pkg::*;
#(
    parameter int QUAT_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [QUAT_WIDTH-1:0] i_quat_x,
    input  logic signed [QUAT_WIDTH-1:0] i_quat_y,
    input  logic signed [QUAT_WIDTH-1:0] i_quat_z,
    input  logic signed [QUAT_WIDTH-1:0] i_quat_w,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [15:0]           o_roll_angle,
    output logic signed [15:0]           o_pitch_angle,
    output logic signed [15:0]           o_yaw_angle,
    output logic                         o_pitch_saturated
);

    localparam int NST = 11 + SQRT_STEPS + CORDIC_STEPS;

    function automatic t_pre f_pre_step(t_pre a, int s);
        logic signed [PRE_W-1:0] lim;
        t_pre r;
        lim = {{(PRE_W-1){1'b0}}, 1'b1} << (PRE_LIMIT_LOG - s);
        r = a;
        if (a.x < lim && a.x > -lim && a.y < lim && a.y > -lim) begin
            r.x = a.x <<< s;
            r.y = a.y <<< s;
        end
        return r;
    endfunction

    function automatic t_cord f_cord_init(t_pre p);
        logic signed [PRE_W-1:0] x2;
        logic signed [PRE_W-1:0] y2;
        t_cord c;
        x2 = p.x;
        y2 = p.y;
        c.zero = (x2 == 0) && (y2 == 0);
        c.x = COR_W'(x2);
        c.y = COR_W'(y2);
        c.ang = '0;
        if (x2 < 0) begin
            if (y2 >= 0) begin
                c.x = COR_W'(y2);
                c.y = -COR_W'(x2);
                c.ang = QUARTER_TURN;
            end else begin
                c.x = -COR_W'(y2);
                c.y = COR_W'(x2);
                c.ang = -QUARTER_TURN;
            end
        end
        return c;
    endfunction

    function automatic t_cord f_cord_step(t_cord c, int i, logic [ANG_W-1:0] at);
        logic signed [COR_W-1:0] dx;
        logic signed [COR_W-1:0] dy;
        t_cord r;
        dx = c.y >>> i;
        dy = c.x >>> i;
        r = c;
        if (c.y >= 0) begin
            r.x = c.x + dx;
            r.y = c.y - dy;
            r.ang = c.ang + signed'(at);
        end else begin
            r.x = c.x - dx;
            r.y = c.y + dy;
            r.ang = c.ang - signed'(at);
        end
        return r;
    endfunction

    function automatic logic signed [16:0] f_rad(logic [63:0] prod, logic neg);
        logic [63:0]        sum;
        logic signed [16:0] q;
        sum = prod + (64'd1 << 47);
        q = signed'({1'b0, sum[63:48]});
        return neg ? -q : q;
    endfunction

    logic [NST-1:0] r_vld;
    logic           w_en;

    assign w_en    = !r_vld[NST-1] || !i_stall;
    assign o_stall = !w_en;
    assign o_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    // Input scaling: wide components keep their top bits, narrow ones are sign extended.
    logic signed [CW-1:0] n_qx, n_qy, n_qz, n_qw;

    if (QUAT_WIDTH > CW) begin : g_narrow
        assign n_qx = i_quat_x[QUAT_WIDTH-1 -: CW];
        assign n_qy = i_quat_y[QUAT_WIDTH-1 -: CW];
        assign n_qz = i_quat_z[QUAT_WIDTH-1 -: CW];
        assign n_qw = i_quat_w[QUAT_WIDTH-1 -: CW];
    end else begin : g_extend
        assign n_qx = CW'(i_quat_x);
        assign n_qy = CW'(i_quat_y);
        assign n_qz = CW'(i_quat_z);
        assign n_qw = CW'(i_quat_w);
    end

    logic signed [CW-1:0] r_qx, r_qy, r_qz, r_qw;
    logic signed [31:0]   r_xx, r_yy, r_zz, r_ww, r_wx, r_yz, r_wz, r_xy, r_wy, r_zx;
    logic signed [ARG_W-1:0] r_n2, r_sxy, r_syz, r_rs, r_ys, r_h;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_qx <= n_qx;
            r_qy <= n_qy;
            r_qz <= n_qz;
            r_qw <= n_qw;

            r_xx <= 32'(r_qx) * 32'(r_qx);
            r_yy <= 32'(r_qy) * 32'(r_qy);
            r_zz <= 32'(r_qz) * 32'(r_qz);
            r_ww <= 32'(r_qw) * 32'(r_qw);
            r_wx <= 32'(r_qw) * 32'(r_qx);
            r_yz <= 32'(r_qy) * 32'(r_qz);
            r_wz <= 32'(r_qw) * 32'(r_qz);
            r_xy <= 32'(r_qx) * 32'(r_qy);
            r_wy <= 32'(r_qw) * 32'(r_qy);
            r_zx <= 32'(r_qz) * 32'(r_qx);

            r_n2  <= ARG_W'(r_ww) + ARG_W'(r_xx) + ARG_W'(r_yy) + ARG_W'(r_zz);
            r_sxy <= ARG_W'(r_xx) + ARG_W'(r_yy);
            r_syz <= ARG_W'(r_yy) + ARG_W'(r_zz);
            r_rs  <= ARG_W'(r_wx) + ARG_W'(r_yz);
            r_ys  <= ARG_W'(r_wz) + ARG_W'(r_xy);
            r_h   <= ARG_W'(r_wy) - ARG_W'(r_zx);
        end
    end

    // Arctangent operands and the two factors under the pitch square root.
    logic signed [ARG_W-1:0] n_p2, n_dif, n_sum;
    t_side                   n_side;
    logic [31:0]             r_u, r_v;
    t_side                   r_side;

    assign n_p2  = r_h <<< 1;
    assign n_dif = r_n2 - n_p2;
    assign n_sum = r_n2 + n_p2;

    always_comb begin
        n_side.roll.x = r_n2 - (r_sxy <<< 1);
        n_side.roll.y = r_rs <<< 1;
        n_side.yaw.x  = r_n2 - (r_syz <<< 1);
        n_side.yaw.y  = r_ys <<< 1;
        n_side.h      = r_h;
        n_side.f.nz   = r_n2 != 0;
        n_side.f.satp = n_p2 >= r_n2;
        n_side.f.satn = -n_p2 >= r_n2;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_u    <= n_dif[32:1];
            r_v    <= n_sum[32:1];
            r_side <= n_side;
        end
    end

    // Square root, one result bit per stage.
    logic [63:0] r_sv [SQRT_STEPS+1];
    logic [63:0] r_sr [SQRT_STEPS+1];
    t_side       r_sd [SQRT_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sv[0] <= 64'(r_u) * 64'(r_v);
            r_sr[0] <= '0;
            r_sd[0] <= r_side;
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] n_t;
        assign n_t = r_sr[k] + BIT;
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (r_sv[k] >= n_t) begin
                    r_sv[k+1] <= r_sv[k] - n_t;
                    r_sr[k+1] <= (r_sr[k] >> 1) + BIT;
                end else begin
                    r_sv[k+1] <= r_sv[k];
                    r_sr[k+1] <= r_sr[k] >> 1;
                end
                r_sd[k+1] <= r_sd[k];
            end
        end
    end

    // Prescale: shift both operands up as far as both stay inside the window of 2^40.
    t_pre   n_pin [LANES];
    t_pre   r_pre [3][LANES];
    t_flags r_pf  [3];

    always_comb begin
        n_pin[LANE_ROLL].x  = PRE_W'(r_sd[SQRT_STEPS].roll.x);
        n_pin[LANE_ROLL].y  = PRE_W'(r_sd[SQRT_STEPS].roll.y);
        n_pin[LANE_PITCH].x = PRE_W'({1'b0, r_sr[SQRT_STEPS][31:0]});
        n_pin[LANE_PITCH].y = PRE_W'(r_sd[SQRT_STEPS].h);
        n_pin[LANE_YAW].x   = PRE_W'(r_sd[SQRT_STEPS].yaw.x);
        n_pin[LANE_YAW].y   = PRE_W'(r_sd[SQRT_STEPS].yaw.y);
    end

    t_cord       r_c  [CORDIC_STEPS+1][LANES];
    t_flags      r_cf [CORDIC_STEPS+1];
    logic [63:0] r_prod [LANES];
    logic        r_neg  [LANES];
    logic        r_zero [LANES];
    t_flags      r_mf;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [ANG_W-1:0] n_mag;
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_pre[0][l] <= f_pre_step(f_pre_step(n_pin[l], 32), 16);
                r_pre[1][l] <= f_pre_step(f_pre_step(r_pre[0][l], 8), 4);
                r_pre[2][l] <= f_pre_step(f_pre_step(r_pre[1][l], 2), 1);
                r_c[0][l]   <= f_cord_init(r_pre[2][l]);
            end
        end

        for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_c[k+1][l] <= f_cord_step(r_c[k][l], k, ATAN_TURNS[k]);
                end
            end
        end

        assign n_mag = r_c[CORDIC_STEPS][l].ang < 0 ? -r_c[CORDIC_STEPS][l].ang
                                                    : r_c[CORDIC_STEPS][l].ang;

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_prod[l] <= 64'(n_mag[31:0]) * 64'(PI_Q30);
                r_neg[l]  <= r_c[CORDIC_STEPS][l].ang < 0;
                r_zero[l] <= r_c[CORDIC_STEPS][l].zero;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pf[0] <= r_sd[SQRT_STEPS].f;
            r_pf[1] <= r_pf[0];
            r_pf[2] <= r_pf[1];
            r_cf[0] <= r_pf[2];
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                r_cf[k+1] <= r_cf[k];
            end
            r_mf <= r_cf[CORDIC_STEPS];
        end
    end

    // Output stage: rounding to Q3.13, roll wrap, pitch clamp, zeros for a zero quaternion.
    logic signed [16:0] n_roll, n_pitch, n_yaw;
    logic               n_sat;

    always_comb begin
        n_roll  = r_zero[LANE_ROLL]  ? '0 : f_rad(r_prod[LANE_ROLL], r_neg[LANE_ROLL]);
        n_pitch = r_zero[LANE_PITCH] ? '0 : f_rad(r_prod[LANE_PITCH], r_neg[LANE_PITCH]);
        n_yaw   = r_zero[LANE_YAW]   ? '0 : f_rad(r_prod[LANE_YAW], r_neg[LANE_YAW]);
        n_sat   = 1'b0;
        if (n_roll < ROLL_WRAP_Q13) begin
            n_roll = n_roll + TWO_PI_Q13;
        end
        if (r_mf.satp) begin
            n_pitch = 17'(HALF_PI_Q13);
            n_sat   = 1'b1;
        end else if (r_mf.satn) begin
            n_pitch = -17'(HALF_PI_Q13);
            n_sat   = 1'b1;
        end
        if (!r_mf.nz) begin
            n_roll  = '0;
            n_pitch = '0;
            n_yaw   = '0;
            n_sat   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_roll_angle      <= n_roll[15:0];
            o_pitch_angle     <= n_pitch[15:0];
            o_yaw_angle       <= n_yaw[15:0];
            o_pitch_saturated <= n_sat;
        end
    end

endmodule

// File: sv/qea_checker.sv
module qea_checker
    import qea_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [15:0] o_roll_angle,
    input logic signed [15:0] o_pitch_angle,
    input logic signed [15:0] o_yaw_angle,
    input logic               o_pitch_saturated
);

    // A stalled word keeps every field.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_roll_angle) && $stable(o_pitch_angle)
            && $stable(o_yaw_angle) && $stable(o_pitch_saturated))
        else $error("stalled result word changed");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_pitch_angle <= HALF_PI_Q13 && o_pitch_angle >= -HALF_PI_Q13)
        else $error("pitch outside half pi");

    a_sat_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pitch_saturated |->
            o_pitch_angle == HALF_PI_Q13 || o_pitch_angle == -HALF_PI_Q13)
        else $error("saturated pitch not clamped");

    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_yaw_angle <= PI_Q13 && o_yaw_angle >= -PI_Q13)
        else $error("yaw outside pi");

    a_roll_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> 17'(o_roll_angle) >= ROLL_WRAP_Q13)
        else $error("roll not wrapped");

endmodule

bind quaternion_to_euler_angles_core qea_checker u_qea_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import qea_pkg::*;

    localparam int QW = 16;
    localparam int PIPE_LAT = 73;
    localparam logic signed [63:0] PRESCALE_CAP = 64'sd1 << 40;
    localparam logic signed [63:0] QTURN = 64'sd1 << 30;
    localparam logic [63:0] PI_TURN_Q30 = 64'd3373259426;
    localparam logic signed [63:0] HALF_PI_RAD = 64'sd12868;
    localparam logic signed [63:0] FULL_TURN_RAD = 64'sd51472;
    localparam logic signed [63:0] ROLL_FLOOR_RAD = -64'sd20480;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic               sat;
    } t_euler;

    // Arctangents of 2^-i in binary angle units, full turn = 2^32.
    logic signed [63:0] atan_step [30] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
        64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
        64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001
    };

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [63:0] atan2_rad(logic signed [63:0] y,
                                                     logic signed [63:0] x);
        logic signed [63:0] ang;
        logic signed [63:0] t;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic [63:0] mag;
        logic [63:0] prod;
        logic signed [63:0] q;
        ang = 0;
        if (x == 0 && y == 0) return 0;
        while (x < PRESCALE_CAP && x > -PRESCALE_CAP &&
               y < PRESCALE_CAP && y > -PRESCALE_CAP) begin
            x = x * 2;
            y = y * 2;
        end
        // Fold the left half plane into the right one by a quarter turn.
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; ang = QTURN;
            end else begin
                t = x; x = -y; y = t; ang = -QTURN;
            end
        end
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx; y = y - dy; ang = ang + atan_step[i];
            end else begin
                x = x - dx; y = y + dy; ang = ang - atan_step[i];
            end
        end
        mag = ang < 0 ? -ang : ang;
        prod = mag * PI_TURN_Q30;
        q = (prod + (64'd1 << 47)) >> 48;
        return ang < 0 ? -q : q;
    endfunction

    function automatic t_euler euler_of(logic signed [QW-1:0] ix, logic signed [QW-1:0] iy,
                                        logic signed [QW-1:0] iz, logic signed [QW-1:0] iw);
        logic signed [63:0] x, y, z, w, xx, yy, zz, ww, n2, h, p2, r, p, yw;
        logic [63:0] u, v;
        t_euler e;
        x = 64'(ix); y = 64'(iy); z = 64'(iz); w = 64'(iw);
        xx = x * x; yy = y * y; zz = z * z; ww = w * w;
        n2 = ww + xx + yy + zz;
        r = 0; p = 0; yw = 0;
        e.sat = 0;
        if (n2 > 0) begin
            h = w * y - z * x;
            p2 = 2 * h;
            r = atan2_rad(2 * (w * x + y * z), n2 - 2 * (xx + yy));
            if (r < ROLL_FLOOR_RAD) r = r + FULL_TURN_RAD;
            if (p2 >= n2) begin
                p = HALF_PI_RAD; e.sat = 1;
            end else if (-p2 >= n2) begin
                p = -HALF_PI_RAD; e.sat = 1;
            end else begin
                u = (n2 - p2) >> 1;
                v = (n2 + p2) >> 1;
                p = atan2_rad(h, int_sqrt(u * v));
            end
            yw = atan2_rad(2 * (w * z + x * y), n2 - 2 * (yy + zz));
        end
        e.roll = r[15:0];
        e.pitch = p[15:0];
        e.yaw = yw[15:0];
        return e;
    endfunction

    class angle_board;
        t_euler pending[$];
        int errors;

        function void note_quat(logic signed [QW-1:0] x, logic signed [QW-1:0] y,
                                logic signed [QW-1:0] z, logic signed [QW-1:0] w);
            pending = {pending, euler_of(x, y, z, w)};
        endfunction

        function void check_angles(t_euler got);
            t_euler want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word %p", $realtime, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.roll !== want.roll) begin
                $display("%0t: roll expected %0d actual %0d", $realtime, want.roll, got.roll);
                errors++;
            end
            if (got.pitch !== want.pitch) begin
                $display("%0t: pitch expected %0d actual %0d", $realtime, want.pitch,
                         got.pitch);
                errors++;
            end
            if (got.yaw !== want.yaw) begin
                $display("%0t: yaw expected %0d actual %0d", $realtime, want.yaw, got.yaw);
                errors++;
            end
            if (got.sat !== want.sat) begin
                $display("%0t: saturation expected %0b actual %0b", $realtime, want.sat,
                         got.sat);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    logic signed [QW-1:0] i_quat_x, i_quat_y, i_quat_z, i_quat_w;
    logic o_valid;
    logic i_stall;
    logic signed [15:0] o_roll_angle, o_pitch_angle, o_yaw_angle;
    logic o_pitch_saturated;

    angle_board board;
    int send_idle_pct;
    int recv_stall_pct;

    quaternion_to_euler_angles_core #(.QUAT_WIDTH(QW)) dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // Receiver side: random stall, results checked on acceptance.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_angles('{o_roll_angle, o_pitch_angle, o_yaw_angle, o_pitch_saturated});
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_quat(logic signed [QW-1:0] x, logic signed [QW-1:0] y,
                             logic signed [QW-1:0] z, logic signed [QW-1:0] w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_quat_x <= x; i_quat_y <= y; i_quat_z <= z; i_quat_w <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_quat(x, y, z, w);
    endtask

    task automatic send_random(int n);
        logic signed [QW-1:0] c [4];
        int mode;
        for (int k = 0; k < n; k++) begin
            mode = $urandom_range(9);
            for (int j = 0; j < 4; j++) c[j] = QW'($urandom);
            // Shape some words toward gimbal lock, tiny norms and axis-aligned cases.
            if (mode == 0) begin
                c[3] = c[1]; c[2] = -c[0];
            end else if (mode == 1) begin
                c[3] = c[1]; c[2] = QW'(c[0] + $urandom_range(2) - 1);
            end else if (mode == 2) begin
                for (int j = 0; j < 4; j++) c[j] = QW'($signed($urandom_range(6)) - 3);
            end else if (mode == 3) begin
                c[$urandom_range(3)] = 0; c[$urandom_range(3)] = 0;
            end
            send_quat(c[0], c[1], c[2], c[3]);
        end
        i_valid <= 0;
    endtask

    task automatic drain;
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        board = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_valid <= 0;
        i_stall <= 0;
        i_quat_x <= 0; i_quat_y <= 0; i_quat_z <= 0; i_quat_w <= 0;
        i_rst_n <= 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_quat(0, 0, 0, 0);
        send_quat(0, 0, 0, 16384);
        send_quat(16384, 0, 0, 0);
        send_quat(0, 16384, 0, 0);
        send_quat(0, 0, 16384, 0);
        send_quat(0, 0, 0, -16384);
        send_quat(-32768, -32768, -32768, -32768);
        send_quat(32767, 32767, 32767, 32767);
        send_quat(32767, -32768, 32767, -32768);
        send_quat(0, 11585, 0, 11585);
        send_quat(0, -11585, 0, 11585);
        send_quat(1000, 5000, -1000, 5000);
        send_quat(0, 0, 1, -1);
        send_quat(1, 0, 0, -1);
        send_quat(-16384, 0, 0, 1);
        send_quat(0, 0, -16384, 1);
        send_quat(1, 1, 1, 1);
        send_quat(-1, 0, 0, 0);
        send_quat(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA);
        send_quat(16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555);
        i_valid <= 0;
        drain();

        send_random(150);
        send_idle_pct = 86;
        send_random(100);
        send_idle_pct = 0;
        recv_stall_pct = 86;
        send_random(100);
        send_idle_pct = 16;
        recv_stall_pct = 16;
        send_random(100);
        // Hold off completely until the pipeline is empty, then resume at full rate.
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_random(80);

        drain();
        repeat (PIPE_LAT + 20) @(posedge i_clk);
        if (board.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// File: files.f
sv/qea_pkg.sv
sv/quaternion_to_euler_angles_core.sv
sv/qea_checker.sv
tb/tb_top.sv
